>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, empty when synthesising.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define FDRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define FDRS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define FDRS_ASSERT(lbl, clk, rst_n, prop)
`define FDRS_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> hdl/fdrs_pkg.sv
// ---------------------------------------------------------------------------
// fdrs_pkg
// Types, constants and helper functions of the flag difference segmenter.
// ---------------------------------------------------------------------------
package fdrs_pkg;

  localparam int unsigned AddrBits = 23;
  localparam int unsigned LenBits  = AddrBits + 1;
  localparam int unsigned KindBits = 3;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);
  localparam int unsigned QCntBits = QPtrBits + 1;

  // Run kinds, in the encoding seen on the output.
  localparam logic [KindBits-1:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [KindBits-1:0] KIND_CODE     = 3'd1;
  localparam logic [KindBits-1:0] KIND_GRAPHICS = 3'd2;
  localparam logic [KindBits-1:0] KIND_BGMAP    = 3'd3;
  localparam logic [KindBits-1:0] KIND_OAM      = 3'd4;
  localparam logic [KindBits-1:0] KIND_SOUND    = 3'd5;
  localparam logic [KindBits-1:0] KIND_DATA     = 3'd6;

  // Flag byte bit positions.
  localparam int unsigned FlagData     = 2;
  localparam int unsigned FlagBlockEnd = 3;
  localparam int unsigned FlagGraphics = 4;
  localparam int unsigned FlagBgmap    = 5;
  localparam int unsigned FlagOam      = 6;
  localparam int unsigned FlagSound    = 7;

  // Bits whose change alone splits a run (data and the four media classes).
  localparam logic [7:0] ClassMask = 8'hF4;

  localparam logic [0:0] RegDumpWhole = 1'b0;

  typedef logic [AddrBits-1:0] addr_t;

  typedef struct packed {
    addr_t                start;
    addr_t                stop;
    logic [LenBits-1:0]   length;
    logic [KindBits-1:0]  kind;
    logic                 mark;
    logic                 done;
    logic                 last;
  } result_t;

  // Up to two results written into the result queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [KindBits-1:0] kind_of(input logic [7:0] f);
    logic [KindBits-1:0] k;
    if (|f[1:0])               k = KIND_CODE;
    else if (f[FlagGraphics])  k = KIND_GRAPHICS;
    else if (f[FlagBgmap])     k = KIND_BGMAP;
    else if (f[FlagOam])       k = KIND_OAM;
    else if (f[FlagSound])     k = KIND_SOUND;
    else if (f[FlagData])      k = KIND_DATA;
    else                       k = KIND_UNKNOWN;
    return k;
  endfunction

  function automatic result_t make_result(input addr_t s, input addr_t e,
                                          input logic [7:0] f, input logic mark,
                                          input logic done, input logic last);
    result_t r;
    addr_t   diff;
    diff     = e - s;
    r.start  = s;
    r.stop   = e;
    r.length = {1'b0, diff} + LenBits'(1);
    r.kind   = kind_of(f);
    r.mark   = mark;
    r.done   = done;
    r.last   = last;
    return r;
  endfunction

endpackage

>>> hdl/flag_diff_range_segmenter_unit.sv
// ---------------------------------------------------------------------------
// flag_diff_range_segmenter_unit
// Path: input register, run tracker, then the result queue that drives the output.
// One pair per cycle while the queue has room; results of a pair leave one at a time.
// Reset clears the scan state, the result queue and dump_whole at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

// The flag pair first lands in an input register. Once the queue has room, the
// run tracker compares it with the previous included byte, updates the scan
// state and writes zero, one or two results into a four-entry queue, whose
// head drives the output stream. The input register advances only while the
// queue holds at most two results, so room for a full pair of results is
// always there; with a consumer that keeps up, one item is taken every cycle.
// dump_whole is written through the register port and is expected to change
// only while the block is idle.
module flag_diff_range_segmenter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] new_flags, [15:8] old_flags
  input  logic        s_axis_tlast_i,   // last
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [22:0] range_start, [45:23] range_end,
                                        // [69:46] range_length, [71:70] zero
  output logic [4:0]  m_axis_tuser_o,   // [2:0] kind, [3] mark_end, [4] scan_done
  output logic        m_axis_tlast_o,   // last_of_run
  // Register port.
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic        dump_whole_q;
  logic        in_valid_q;
  logic [7:0]  new_flags_q, old_flags_q;
  logic        last_q;
  logic        advance, take;

  fdrs_pkg::push_t                   push;
  fdrs_pkg::result_t                 head;
  logic                              head_valid;
  logic [fdrs_pkg::QCntBits-1:0]     q_count;

  // Register port: a single one-bit register, decoded from paddr_i[2] only (indices 0 to 3).
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == fdrs_pkg::RegDumpWhole) ? {31'd0, dump_whole_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_whole_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i &&
                 (paddr_i[2] == fdrs_pkg::RegDumpWhole)) begin
      dump_whole_q <= pwdata_i[0];
    end
  end

  // The tracker works on the held pair whenever the queue can take two
  // results, so the input register frees up in the same cycle.
  assign advance         = in_valid_q && (q_count <= fdrs_pkg::QCntBits'(2));
  assign s_axis_tready_o = !in_valid_q || advance;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      new_flags_q <= s_axis_tdata_i[7:0];
      old_flags_q <= s_axis_tdata_i[15:8];
      last_q      <= s_axis_tlast_i;
    end
  end

  fdrs_seg u_seg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (advance),
    .new_flags_i  (new_flags_q),
    .old_flags_i  (old_flags_q),
    .last_i       (last_q),
    .dump_whole_i (dump_whole_q),
    .push_o       (push)
  );

  fdrs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_i      (m_axis_tready_i),
    .head_o     (head),
    .nonempty_o (head_valid),
    .count_o    (q_count)
  );

  assign m_axis_tvalid_o = head_valid;
  assign m_axis_tdata_o  = {2'b00, head.length, head.stop, head.start};
  assign m_axis_tuser_o  = {head.done, head.mark, head.kind};
  assign m_axis_tlast_o  = head.last;

  // The queue never overflows its four entries.
  `FDRS_ASSERT_NEVER(a_queue_bound, clk_i, rst_ni, q_count > fdrs_pkg::QCntBits'(fdrs_pkg::QDepth))
  // Results are only written while room for two remains.
  `FDRS_ASSERT(a_push_room, clk_i, rst_ni, (push.cnt != 2'd0) |-> (q_count <= fdrs_pkg::QCntBits'(2)))
  // The final run of a scan never asks for a block-end mark.
  `FDRS_ASSERT(a_final_unmarked, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o[4]) |-> !m_axis_tuser_o[3])
  // The final run is always the last result of its item.
  `FDRS_ASSERT(a_final_last, clk_i, rst_ni, (m_axis_tvalid_o && m_axis_tuser_o[4]) |-> m_axis_tlast_o)

endmodule

>>> hdl/fdrs_seg.sv
// ---------------------------------------------------------------------------
// fdrs_seg
// Run tracking: scan state and the results that one flag pair causes.
// ---------------------------------------------------------------------------
module fdrs_seg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        new_flags_i,
  input  logic [7:0]        old_flags_i,
  input  logic              last_i,
  input  logic              dump_whole_i,
  output fdrs_pkg::push_t   push_o
);

  fdrs_pkg::addr_t pos_q, prev_addr_q, run_start_q;
  fdrs_pkg::addr_t pos_d, prev_addr_d, run_start_d;
  logic [7:0]      prev_flags_q, prev_flags_d;
  logic            have_q, have_d;

  logic            incl, split, emit_split, emit_final;
  fdrs_pkg::addr_t next_addr;
  fdrs_pkg::result_t res_split, res_final;

  always_comb begin
    next_addr = prev_addr_q + fdrs_pkg::addr_t'(1);
    incl      = dump_whole_i | (new_flags_i != old_flags_i);
    split     = new_flags_i[fdrs_pkg::FlagBlockEnd]
              | (next_addr != pos_q)
              | (|((new_flags_i ^ prev_flags_q) & fdrs_pkg::ClassMask))
              | ((|new_flags_i[1:0]) != (|prev_flags_q[1:0]));

    emit_split = valid_i & incl & have_q & split;

    // Scan state after this item, before any end-of-scan clear.
    run_start_d  = (incl & (!have_q | split)) ? pos_q : run_start_q;
    prev_addr_d  = incl ? pos_q : prev_addr_q;
    prev_flags_d = incl ? new_flags_i : prev_flags_q;
    have_d       = have_q | incl;
    pos_d        = pos_q + fdrs_pkg::addr_t'(1);

    emit_final = valid_i & last_i & have_d;

    res_split = fdrs_pkg::make_result(run_start_q, prev_addr_q, prev_flags_q,
                                      !dump_whole_i, 1'b0, !emit_final);
    res_final = fdrs_pkg::make_result(run_start_d, prev_addr_d, prev_flags_d,
                                      1'b0, 1'b1, 1'b1);

    push_o.cnt = {1'b0, emit_split} + {1'b0, emit_final};
    push_o.r0  = emit_split ? res_split : res_final;
    push_o.r1  = res_final;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      prev_addr_q  <= '0;
      run_start_q  <= '0;
      prev_flags_q <= '0;
      have_q       <= 1'b0;
    end else if (valid_i) begin
      if (last_i) begin
        pos_q        <= '0;
        prev_addr_q  <= '0;
        run_start_q  <= '0;
        prev_flags_q <= '0;
        have_q       <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        prev_addr_q  <= prev_addr_d;
        run_start_q  <= run_start_d;
        prev_flags_q <= prev_flags_d;
        have_q       <= have_d;
      end
    end
  end

endmodule

>>> hdl/fdrs_queue.sv
// ---------------------------------------------------------------------------
// fdrs_queue
// Small result queue: takes up to two results a cycle, gives one.
// ---------------------------------------------------------------------------
module fdrs_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fdrs_pkg::push_t                   push_i,
  input  logic                              pop_i,
  output fdrs_pkg::result_t                 head_o,
  output logic                              nonempty_o,
  output logic [fdrs_pkg::QCntBits-1:0]     count_o
);

  fdrs_pkg::result_t                  slot_q [fdrs_pkg::QDepth];
  logic [fdrs_pkg::QPtrBits-1:0]      wr_q, rd_q, wr_d, rd_d, wr_next;
  logic [fdrs_pkg::QCntBits-1:0]      cnt_q, cnt_d;
  logic                               do_pop;

  always_comb begin
    do_pop  = pop_i & (cnt_q != '0);
    wr_next = wr_q + fdrs_pkg::QPtrBits'(1);
    wr_d    = wr_q + fdrs_pkg::QPtrBits'(push_i.cnt);
    rd_d    = rd_q + fdrs_pkg::QPtrBits'(do_pop);
    cnt_d   = cnt_q + fdrs_pkg::QCntBits'(push_i.cnt)
            - fdrs_pkg::QCntBits'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      slot_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      slot_q[wr_next] <= push_i.r1;
    end
  end

  assign head_o     = slot_q[rd_q];
  assign nonempty_o = (cnt_q != '0);
  assign count_o    = cnt_q;

endmodule
